[rtl/core/ads_pkg.sv]
// Shared constants, codes and types of the advertisement duplicate suppressor.
// Used by the channel interfaces, the controller, the datapath and the checker.
// No dependencies.
package ads_pkg;

	localparam int TABLE_DEPTH       = 16;
	localparam int MAX_PAYLOAD_BYTES = 31;
	localparam int IDX_W             = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int ADDR_W    = 48;
	localparam int TIME_W    = 32;
	localparam int LEN_W     = 5;
	localparam int CUT_W     = 16;
	localparam int WORD_W    = 64;
	localparam int WORD3_W   = 56;
	localparam int IN_PAY_W  = 3 * WORD_W + WORD3_W;
	localparam int PAY_W     = 8 * MAX_PAYLOAD_BYTES;
	localparam int OUTCOME_W = 3;

	localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(MAX_PAYLOAD_BYTES);
	localparam logic [CUT_W-1:0] CUTOFF_RESET  = CUT_W'(3);

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_NEW     = 3'd0,
		OUT_DROP    = 3'd1,
		OUT_AFTER   = 3'd2,
		OUT_CHANGED = 3'd3,
		OUT_FULL    = 3'd4
	} ads_outcome_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] last_seen;
		logic [LEN_W-1:0]  len;
		logic [PAY_W-1:0]  pay;
	} ads_entry_t;

	typedef struct packed {
		logic load_in;
		logic scan_rd;
		logic eval;
		logic commit;
		logic deliver;
	} ads_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} ads_sts_t;

endpackage

[rtl/core/ads_if.sv]
// Valid/ready channel interfaces: advertisement input, result output and
// configuration write. Depends on ads_pkg for field widths.
interface ads_in_if import ads_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   device_address;
	logic [TIME_W-1:0]   now_seconds;
	logic [LEN_W-1:0]    payload_length;
	logic [WORD_W-1:0]   payload_word_0;
	logic [WORD_W-1:0]   payload_word_1;
	logic [WORD_W-1:0]   payload_word_2;
	logic [WORD3_W-1:0]  payload_word_3;

	modport source (output valid, device_address, now_seconds, payload_length,
		payload_word_0, payload_word_1, payload_word_2, payload_word_3, input ready);
	modport sink (input valid, device_address, now_seconds, payload_length,
		payload_word_0, payload_word_1, payload_word_2, payload_word_3, output ready);
endinterface

interface ads_out_if import ads_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 forward;
	logic [OUTCOME_W-1:0] outcome;

	modport source (output valid, forward, outcome, input ready);
	modport sink (input valid, forward, outcome, output ready);
endinterface

interface ads_cfg_if import ads_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CUT_W-1:0] cutoff_seconds;

	modport source (output valid, cutoff_seconds, input ready);
	modport sink (input valid, cutoff_seconds, output ready);
endinterface

[rtl/core/ads_ctrl.sv]
// Controller state machine of the duplicate suppressor: sequences capture,
// table scan, evaluation, write-back and delivery. Depends on ads_pkg.
module ads_ctrl import ads_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ads_sts_t sts,
	output ads_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_COMMIT,
		ST_DELIVER
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_SCAN;
						in_ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:  state_q <= ST_EVAL;
				ST_EVAL:   state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= ST_DELIVER;
				ST_DELIVER: begin
					if (sts.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:    cmd.load_in = in_valid && in_ready_q;
			ST_SCAN:    cmd.scan_rd = 1'b1;
			ST_DRAIN:   cmd = '0;
			ST_EVAL:    cmd.eval    = 1'b1;
			ST_COMMIT:  cmd.commit  = 1'b1;
			ST_DELIVER: cmd.deliver = sts.out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

[rtl/core/ads_datapath.sv]
// Datapath of the duplicate suppressor: input capture, device table memory,
// scan compare, outcome evaluation and output register. Depends on ads_pkg.
module ads_datapath import ads_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ads_cmd_t             cmd,
	output ads_sts_t             sts,
	input  logic [ADDR_W-1:0]    in_device_address,
	input  logic [TIME_W-1:0]    in_now_seconds,
	input  logic [LEN_W-1:0]     in_payload_length,
	input  logic [WORD_W-1:0]    in_payload_word_0,
	input  logic [WORD_W-1:0]    in_payload_word_1,
	input  logic [WORD_W-1:0]    in_payload_word_2,
	input  logic [WORD3_W-1:0]   in_payload_word_3,
	input  logic                 cfg_valid,
	input  logic [CUT_W-1:0]     cfg_cutoff_seconds,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_forward,
	output logic [OUTCOME_W-1:0] out_outcome
);

	logic [CUT_W-1:0]       cutoff_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [TIME_W-1:0]      now_q;
	logic [LEN_W-1:0]       len_q;
	logic [PAY_W-1:0]       pay_q;
	logic [LEN_W-1:0]       len_sat;
	logic [IN_PAY_W-1:0]    raw_all;
	logic [PAY_W-1:0]       pay_masked;

	logic [IDX_W-1:0]       scan_idx_q;
	ads_entry_t             entry_mem [TABLE_DEPTH];
	ads_entry_t             rd_row_s1;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic                   hit_found_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [IDX_W-1:0]       free_idx_q;
	ads_entry_t             hit_row_q;
	logic                   row_hit;
	logic                   row_free;

	logic                   same;
	logic [TIME_W-1:0]      elapsed;
	ads_outcome_t           outcome_nxt;
	ads_outcome_t           outcome_q;
	logic                   keep_payload;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_idx;
	ads_entry_t             wr_row;

	logic                   out_valid_q;
	logic                   out_forward_q;
	ads_outcome_t           out_outcome_q;

	// Configuration register; the port is always ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
		end else if (cfg_valid) begin
			cutoff_q <= cfg_cutoff_seconds;
		end
	end

	// Length saturation and clearing of the bytes beyond the length.
	assign len_sat = (in_payload_length > MAX_LEN) ? MAX_LEN : in_payload_length;
	assign raw_all = {in_payload_word_3, in_payload_word_2, in_payload_word_1,
		in_payload_word_0};

	always_comb begin
		for (int b = 0; b < MAX_PAYLOAD_BYTES; b++) begin
			pay_masked[8*b +: 8] = (b < int'(len_sat)) ? raw_all[8*b +: 8] : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			addr_q <= in_device_address;
			now_q  <= in_now_seconds;
			len_q  <= len_sat;
			pay_q  <= pay_masked;
		end
	end

	// Scan counter and the registered read of the table memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			if (cmd.load_in) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			rd_vld_s1 <= cmd.scan_rd;
			rd_idx_s1 <= scan_idx_q;
		end
	end

	assign sts.scan_last = (scan_idx_q == IDX_W'(TABLE_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_row_s1 <= entry_mem[scan_idx_q];
		end
		if (wr_en) begin
			entry_mem[wr_idx] <= wr_row;
		end
	end

	// First matching valid entry and lowest free entry, in scan order.
	assign row_hit  = rd_vld_s1 && valid_q[rd_idx_s1] && (rd_row_s1.addr == addr_q);
	assign row_free = rd_vld_s1 && !valid_q[rd_idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load_in) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (row_hit) begin
				hit_found_q <= 1'b1;
			end
			if (row_free) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (row_hit && !hit_found_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_row_q <= rd_row_s1;
		end
		if (row_free && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// Outcome: elapsed time wraps modulo 2^32 by the width of the subtraction.
	assign same    = (hit_row_q.len == len_q) && (hit_row_q.pay == pay_q);
	assign elapsed = now_q - hit_row_q.last_seen;

	always_comb begin
		if (hit_found_q) begin
			if (same) begin
				outcome_nxt = (elapsed <= TIME_W'(cutoff_q)) ? OUT_DROP : OUT_AFTER;
			end else begin
				outcome_nxt = OUT_CHANGED;
			end
		end else if (free_found_q) begin
			outcome_nxt = OUT_NEW;
		end else begin
			outcome_nxt = OUT_FULL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			outcome_q <= outcome_nxt;
		end
	end

	// Write-back: a known device always takes the new time; its length and
	// payload change only when the advertisement differs.
	assign keep_payload = (outcome_q == OUT_DROP) || (outcome_q == OUT_AFTER);
	assign wr_en        = cmd.commit && (hit_found_q || free_found_q);
	assign wr_idx       = hit_found_q ? hit_idx_q : free_idx_q;

	always_comb begin
		wr_row.addr      = addr_q;
		wr_row.last_seen = now_q;
		wr_row.len       = keep_payload ? hit_row_q.len : len_q;
		wr_row.pay       = keep_payload ? hit_row_q.pay : pay_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && !hit_found_q && free_found_q) begin
			valid_q[free_idx_q] <= 1'b1;
		end
	end

	// Output register; it parts the result from the next capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			out_forward_q <= (outcome_q != OUT_DROP);
			out_outcome_q <= outcome_q;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_forward  = out_forward_q;
	assign out_outcome  = out_outcome_q;

endmodule

[rtl/core/advert_duplicate_suppressor_core.sv]
// Top level of the advertisement duplicate suppressor.
// Each advertisement passes through capture, one table read per entry, drain,
// evaluate, write back and deliver; the next one is taken only after delivery.
// Reset: arst_n clears the state machine, valid bits and output register at
// once; cutoff_seconds returns to 3. No clearing pass over the table is needed.
module advert_duplicate_suppressor_core import ads_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ads_in_if.sink     advert,
	ads_out_if.source  result,
	ads_cfg_if.sink    cfg
);

	// The controller and datapath talk only through these two structs.
	ads_cmd_t cmd;
	ads_sts_t sts;

	// The controller owns the input ready. It is high only between items, so
	// exactly one advertisement is being worked on at a time. A finished
	// result sits in the datapath's output register, so a new transfer on the
	// input can be taken while the previous result still waits downstream.
	ads_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (advert.valid),
		.in_ready (advert.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the device table as a memory of TABLE_DEPTH rows,
	// each row one whole entry (address, last-seen time, length, payload).
	// The scan reads one row a cycle; the first valid row with a matching
	// address and the lowest invalid row are recorded as the scan drains.
	ads_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_device_address  (advert.device_address),
		.in_now_seconds     (advert.now_seconds),
		.in_payload_length  (advert.payload_length),
		.in_payload_word_0  (advert.payload_word_0),
		.in_payload_word_1  (advert.payload_word_1),
		.in_payload_word_2  (advert.payload_word_2),
		.in_payload_word_3  (advert.payload_word_3),
		.cfg_valid          (cfg.valid),
		.cfg_cutoff_seconds (cfg.cutoff_seconds),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.out_forward        (result.forward),
		.out_outcome        (result.outcome)
	);

	// Configuration writes complete in the cycle they are offered.
	assign cfg.ready = 1'b1;

endmodule

[rtl/core/ads_checker.sv]
// Port-level checker for the duplicate suppressor, with its bind statement.
// Depends on ads_pkg and the top level advert_duplicate_suppressor_core.
module ads_checker import ads_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 forward,
	input logic [OUTCOME_W-1:0] outcome
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its fields.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(forward) && $stable(outcome))
		else $error("result changed while stalled");

	// Only a dropped repeat is not forwarded.
	a_forward_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (forward == (outcome != OUT_DROP)))
		else $error("forward flag disagrees with outcome");

	// One advertisement at a time: the input closes after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready after a transfer");

endmodule

bind advert_duplicate_suppressor_core ads_checker u_ads_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (advert.valid),
	.in_ready  (advert.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.forward   (result.forward),
	.outcome   (result.outcome)
);
